// File: hw/rtl/stp_pkg.sv
// shared types, constants and character helpers of the string to integer parser
package stp_pkg;

   // default sizes
   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_LEN_DEF     = 4096;

   // fixed field widths
   localparam int CH_W    = 8;
   localparam int BASE_W  = 6;
   localparam int INDEX_W = 13;
   localparam int CSR_W   = 6;

   // register indexes
   localparam logic CSR_NUMBER_BASE   = 1'b0;
   localparam logic CSR_UNSIGNED_KIND = 1'b1;

   // bases and characters
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;

   localparam logic [CH_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CH_W-1:0] CH_CR      = 8'd13;
   localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [CH_W-1:0] CH_PLUS    = 8'h2b;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5a;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7a;
   localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CH_W-1:0] DIGIT_OFS  = 8'd10;

   // parser phases
   typedef enum logic [2:0] {
      PH_DONE,
      PH_SPACE,
      PH_PREFIX,
      PH_XCHECK,
      PH_DIGITS
   } stp_phase_type;

   // one input word
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            first;
   } stp_item_type;

   // input register contents
   typedef struct packed {
      logic         valid;
      stp_item_type item;
   } stp_slot_type;

   // configuration registers
   typedef struct packed {
      logic [BASE_W-1:0] number_base;
      logic              unsigned_kind;
   } stp_cfg_type;

   // digit lookup result
   typedef struct packed {
      logic              valid;
      logic [BASE_W-1:0] digit;
   } stp_digit_type;

   function automatic logic is_space(input logic [CH_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic base_invalid(input logic [BASE_W-1:0] b);
      return (b == BASE_ONE) || (b > BASE_MAX);
   endfunction

   // digit value of c in radix b
   function automatic stp_digit_type digit_of(input logic [BASE_W-1:0] b,
                                              input logic [CH_W-1:0] c);
      stp_digit_type   r;
      logic [CH_W-1:0] d;
      logic            hit;
      d   = '0;
      hit = 1'b1;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d = c - CH_ZERO;
      end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
         d = c - CH_LOWER_A + DIGIT_OFS;
      end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
         d = c - CH_UPPER_A + DIGIT_OFS;
      end else begin
         hit = 1'b0;
      end
      r.digit = d[BASE_W-1:0];
      r.valid = hit && (d < {2'b00, b});
      return r;
   endfunction

endpackage

// File: hw/rtl/stp_if.sv
// handshake channels for characters in and parse results out
interface stp_req_if
   import stp_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            first;

   modport source (output valid, output ch, output first, input ready);
   modport sink   (input valid, input ch, input first, output ready);
endinterface

interface stp_rsp_if
   import stp_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;
   logic [INDEX_W-1:0]     end_index;
   logic                   bad_base;

   modport source (output valid, output value, output end_index, output bad_base,
                   input ready);
   modport sink   (input valid, input value, input end_index, input bad_base,
                   output ready);
endinterface

// File: hw/rtl/stp_in_stage.sv
// input register that holds one character word for the step logic
module stp_in_stage
   import stp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   stp_req_if.sink      req_if,
   input  logic         take,
   output stp_slot_type slot
);

   logic         valid_ff, valid_in;
   stp_item_type item_ff;
   logic         load;

   // free slot or slot emptied this cycle
   assign req_if.ready = !valid_ff || take;
   assign load         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.ch    <= req_if.ch;
         item_ff.first <= req_if.first;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.item  = item_ff;

endmodule

// File: hw/rtl/stp_core.sv
// parser state, one step of character logic and the result register
module stp_core
   import stp_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_LEN     = MAX_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  stp_slot_type slot,
   input  stp_cfg_type  cfg,
   output logic         take,
   stp_rsp_if.source    rsp_if
);

   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
   localparam logic [VALUE_WIDTH-1:0] UMAX = {VALUE_WIDTH{1'b1}};
   localparam logic [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   // state registers
   stp_phase_type          phase_ff, phase_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]       pos_ff, pos_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [INDEX_W-1:0]     end_ff, end_in;
   logic                   bad_ff, bad_in;

   // step working values
   logic                        handled;
   logic                        emit;
   logic                        step_adv;
   logic [CH_W-1:0]             c;
   logic                        first;
   logic [VALUE_WIDTH-1:0]      acc_w;
   logic [VALUE_WIDTH+BASE_W-1:0] prod;
   logic [VALUE_WIDTH-1:0]      mac;
   logic [POS_W-1:0]            pos_w;
   logic [POS_W-1:0]            pos_next;
   logic [31:0]                 pos_ext;
   stp_digit_type               dig;

   assign c     = slot.item.ch;
   assign first = slot.item.first;

   // step when the result register is free or being drained
   assign take = slot.valid && (!rsp_valid_ff || rsp_if.ready);

   // restart clears the working copies
   assign acc_w = first ? '0 : acc_ff;
   assign pos_w = first ? '0 : pos_ff;

   // saturating position advance
   assign pos_next = (pos_w < POS_LIMIT) ? pos_w + POS_W'(1) : POS_LIMIT;

   // digit lookup and multiply-add use the base chosen within the step
   assign dig  = digit_of(base_in, c);
   assign prod = {{BASE_W{1'b0}}, acc_w} * {{VALUE_WIDTH{1'b0}}, base_in};
   assign mac  = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(dig.digit);

   // next state and result for one character
   always_comb begin
      phase_in = phase_ff;
      base_in  = base_ff;
      neg_in   = neg_ff;
      acc_in   = acc_w;
      pos_in   = pos_w;
      handled  = 1'b0;
      emit     = 1'b0;
      step_adv = 1'b0;
      bad_in   = 1'b0;
      value_in = value_ff;
      end_in   = end_ff;
      if (first) begin
         neg_in = 1'b0;
         if (base_invalid(cfg.number_base)) begin
            handled  = 1'b1;
            emit     = 1'b1;
            bad_in   = 1'b1;
            phase_in = PH_DONE;
            value_in = cfg.unsigned_kind ? UMAX : SMAX;
            end_in   = '0;
         end else begin
            base_in  = cfg.number_base;
            phase_in = PH_SPACE;
         end
      end
      if (!handled && (phase_in == PH_DONE)) begin
         handled = 1'b1;
      end
      // whitespace and sign
      if (!handled && (phase_in == PH_SPACE)) begin
         if (is_space(c)) begin
            handled  = 1'b1;
            step_adv = 1'b1;
         end else begin
            phase_in = PH_PREFIX;
            if ((c == CH_MINUS) || (c == CH_PLUS)) begin
               neg_in   = (c == CH_MINUS);
               handled  = 1'b1;
               step_adv = 1'b1;
            end
         end
      end
      // leading zero of a prefix
      if (!handled && (phase_in == PH_PREFIX)) begin
         phase_in = PH_DIGITS;
         if ((base_in == BASE_HEX) && (c == CH_ZERO)) begin
            phase_in = PH_XCHECK;
            handled  = 1'b1;
            step_adv = 1'b1;
         end else if (base_in == BASE_AUTO) begin
            if (c == CH_ZERO) begin
               base_in  = BASE_OCT;
               phase_in = PH_XCHECK;
               handled  = 1'b1;
               step_adv = 1'b1;
            end else begin
               base_in = BASE_DEC;
            end
         end
      end
      // lower-case x after the zero
      if (!handled && (phase_in == PH_XCHECK)) begin
         phase_in = PH_DIGITS;
         if (c == CH_LOWER_X) begin
            base_in  = BASE_HEX;
            handled  = 1'b1;
            step_adv = 1'b1;
         end
      end
      // digits, or the end of the number
      if (!handled) begin
         if (dig.valid) begin
            acc_in   = mac;
            step_adv = 1'b1;
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
            value_in = neg_in ? (~acc_w + VALUE_WIDTH'(1)) : acc_w;
            end_in   = pos_ext[INDEX_W-1:0];
         end
      end
      if (step_adv) begin
         pos_in = pos_next;
      end
   end

   assign pos_ext = 32'(pos_w);

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         base_ff      <= '0;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            base_ff  <= base_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            pos_ff   <= pos_in;
         end
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (take && emit) begin
         value_ff <= value_in;
         end_ff   <= end_in;
         bad_ff   <= bad_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.value     = value_ff;
   assign rsp_if.end_index = end_ff;
   assign rsp_if.bad_base  = bad_ff;

   // a bad base result always points at the first character
   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && bad_ff) |-> (end_ff == '0))
      else $error("bad base result with nonzero end index");

   // an emitted result leaves the parser done
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (take && emit) |=> (phase_ff == PH_DONE))
      else $error("parser not done after result");

   // a done parser ignores words until a restart
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (take && !first && (phase_ff == PH_DONE)) |-> !emit)
      else $error("result from idle parser");

   // digit phase always runs with a resolved radix
   a_digit_base: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGITS) |-> ((base_ff >= 6'd2) && (base_ff <= BASE_MAX)))
      else $error("digit phase with unresolved base");

   // position saturates
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("position beyond limit");

endmodule

// File: hw/rtl/string_to_integer_parser.sv
// Streaming strtol-style parser: one character word per cycle in while no result
// waits unaccepted, at most one result per string out. A word is held in the input
// register until the step logic takes it. The step is whitespace/sign/prefix/digit
// logic with a VALUE_WIDTH by 6 bit multiply-add, and it writes the result register.
// So a result is offered from the result register once the word that ends the number
// has passed through the input register and the step logic. While a result waits
// unaccepted the step logic stalls, and at most one more word is taken into the input
// register. number_base (0 auto, 2..36) is sampled on the word with first set; an
// invalid base yields the signed or unsigned maximum with bad_base and end_index 0 on
// that word. Values wrap modulo 2^VALUE_WIDTH, and the position saturates at MAX_LEN.
module string_to_integer_parser
   import stp_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_LEN     = MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   stp_req_if.sink          req_if,
   stp_rsp_if.source        rsp_if,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_write_data
);

   // configuration registers
   logic [BASE_W-1:0] number_base_ff, number_base_in;
   logic              unsigned_kind_ff, unsigned_kind_in;
   stp_cfg_type       cfg;
   stp_slot_type      slot;
   logic              take;

   always_comb begin
      number_base_in   = number_base_ff;
      unsigned_kind_in = unsigned_kind_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NUMBER_BASE:   number_base_in   = csr_write_data[BASE_W-1:0];
            CSR_UNSIGNED_KIND: unsigned_kind_in = csr_write_data[0];
            default:           number_base_in   = number_base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff   <= BASE_DEC;
         unsigned_kind_ff <= 1'b0;
      end else begin
         number_base_ff   <= number_base_in;
         unsigned_kind_ff <= unsigned_kind_in;
      end
   end

   assign cfg.number_base   = number_base_ff;
   assign cfg.unsigned_kind = unsigned_kind_ff;

   // input register
   stp_in_stage u_in_stage (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .take   (take),
      .slot   (slot)
   );

   // step logic and result register
   stp_core #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_LEN     (MAX_LEN)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .slot   (slot),
      .cfg    (cfg),
      .take   (take),
      .rsp_if (rsp_if)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the string to integer parser
module testbench;
   import stp_pkg::*;

   localparam int VW            = VALUE_WIDTH_DEF;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 250;
   localparam int RANDOM_WORDS  = 1640;
   localparam int PHASE_WORDS   = 150;
   localparam int BAD_STRINGS   = 20;

   localparam logic [VW-1:0] SIGNED_MAX   = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] UNSIGNED_MAX = {VW{1'b1}};

   // one parse result as it leaves the block
   typedef struct {
      logic [VW-1:0]      value;
      logic [INDEX_W-1:0] end_index;
      logic               bad_base;
   } number_outcome_type;

   // parser shadow state and queue of numbers still to come out
   class parse_scoreboard;
      logic [BASE_W-1:0]  base_reg;
      logic               kind_reg;
      stp_phase_type      phase;
      logic [BASE_W-1:0]  radix;
      bit                 negative;
      logic [VW-1:0]      acc;
      int unsigned        position;
      number_outcome_type pending_numbers[$];
      int                 errors;

      function new();
         base_reg = BASE_DEC;
         kind_reg = 1'b0;
         phase    = PH_DONE;
         radix    = '0;
         negative = 1'b0;
         acc      = '0;
         position = 0;
         errors   = 0;
      endfunction

      function void set_register(logic idx, logic [CSR_W-1:0] data);
         if (idx == CSR_NUMBER_BASE) begin
            base_reg = data[BASE_W-1:0];
         end else begin
            kind_reg = data[0];
         end
      endfunction

      // consume one character, position saturates at the length limit
      function void advance();
         if (position < MAX_LEN_DEF) begin
            position++;
         end
      endfunction

      function void push_number(logic [VW-1:0] v, int unsigned idx, logic bad);
         number_outcome_type n;
         n.value     = v;
         n.end_index = idx[INDEX_W-1:0];
         n.bad_base  = bad;
         pending_numbers.push_back(n);
      endfunction

      // alphanumeric value regardless of radix, -1 for anything else
      function int char_weight(logic [CH_W-1:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
         end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            return int'(c - CH_LOWER_A) + 10;
         end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return int'(c - CH_UPPER_A) + 10;
         end
         return -1;
      endfunction

      // returns 1 when the word was consumed rather than ignored
      function bit note_word(logic [CH_W-1:0] c, logic start);
         int            d;
         logic [VW-1:0] v;
         if (start) begin
            position = 0;
            negative = 1'b0;
            acc      = '0;
            if (base_reg == BASE_ONE || base_reg > BASE_MAX) begin
               push_number(kind_reg ? UNSIGNED_MAX : SIGNED_MAX, 0, 1'b1);
               phase = PH_DONE;
               return 1'b1;
            end
            radix = base_reg;
            phase = PH_SPACE;
         end
         if (phase == PH_DONE) begin
            return 1'b0;
         end
         // leading whitespace and one sign
         if (phase == PH_SPACE) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
               advance();
               return 1'b1;
            end
            phase = PH_PREFIX;
            if (c == CH_MINUS || c == CH_PLUS) begin
               negative = (c == CH_MINUS);
               advance();
               return 1'b1;
            end
         end
         // leading zero selects octal in auto mode, may start 0x in hex
         if (phase == PH_PREFIX) begin
            phase = PH_DIGITS;
            if (radix == BASE_HEX && c == CH_ZERO) begin
               phase = PH_XCHECK;
               advance();
               return 1'b1;
            end
            if (radix == BASE_AUTO) begin
               if (c == CH_ZERO) begin
                  radix = BASE_OCT;
                  phase = PH_XCHECK;
                  advance();
                  return 1'b1;
               end
               radix = BASE_DEC;
            end
         end
         // only lowercase x completes the hex prefix
         if (phase == PH_XCHECK) begin
            phase = PH_DIGITS;
            if (c == CH_LOWER_X) begin
               radix = BASE_HEX;
               advance();
               return 1'b1;
            end
         end
         // digits wrap modulo 2^VW, anything else ends the number
         d = char_weight(c);
         if (d >= 0 && d < int'(radix)) begin
            acc = acc * VW'(radix) + VW'(d);
            advance();
            return 1'b1;
         end
         v = negative ? (VW'(0) - acc) : acc;
         push_number(v, position, 1'b0);
         phase = PH_DONE;
         return 1'b1;
      endfunction

      function void check_result(logic [VW-1:0] value, logic [INDEX_W-1:0] end_index,
                                 logic bad_base);
         number_outcome_type want;
         if (pending_numbers.size() == 0) begin
            $display("%0t: unexpected result value %h end_index %0d bad_base %b",
                     $time, value, end_index, bad_base);
            errors++;
            return;
         end
         want = pending_numbers.pop_front();
         if (value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, value);
            errors++;
         end
         if (end_index !== want.end_index) begin
            $display("%0t: end_index expected %0d actual %0d",
                     $time, want.end_index, end_index);
            errors++;
         end
         if (bad_base !== want.bad_base) begin
            $display("%0t: bad_base expected %b actual %b", $time, want.bad_base, bad_base);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic             csr_index;
   logic [CSR_W-1:0] csr_write_data;

   stp_req_if                           req_ch ();
   stp_rsp_if #(.VALUE_WIDTH(VW))       rsp_ch ();

   parse_scoreboard sb;
   bit              pacing_on;
   bit              drain_hold_req;
   int              sent_words;
   int              cycle_count;

   string_to_integer_parser #(
      .VALUE_WIDTH(VW),
      .MAX_LEN    (MAX_LEN_DEF)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_ch),
      .rsp_if          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("string_to_integer_parser verification failed");
         $finish;
      end
   end

   // watch both channels, results checked before the word of this edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.value, rsp_ch.end_index, rsp_ch.bad_base);
         end
         if (req_ch.valid && req_ch.ready) begin
            void'(sb.note_word(req_ch.ch, req_ch.first));
            sent_words++;
         end
      end
   end

   // result side: random stalls, plus a long hold when asked for
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = pacing_on ? $urandom_range(0, 5) : 0;
         if (drain_hold_req) begin
            stall += HOLD_CYCLES;
            drain_hold_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // offer one character word, return at the edge that takes it
   task automatic send_word(input logic [CH_W-1:0] c, input logic start);
      int gap;
      gap = pacing_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.ch    <= c;
      req_ch.first <= start;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_text(input string s, input bit start, input bit with_nul);
      for (int i = 0; i < s.len(); i++) begin
         send_word(s[i], start && (i == 0));
      end
      if (with_nul) begin
         send_word(8'h00, 1'b0);
      end
   endtask

   // stop offering and let every pending number come out
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers while the parser is quiet
   task automatic configure(input logic [BASE_W-1:0] base, input logic kind);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_NUMBER_BASE;
      csr_write_data   <= CSR_W'(base);
      sb.set_register(CSR_NUMBER_BASE, CSR_W'(base));
      @(posedge clock);
      csr_index        <= CSR_UNSIGNED_KIND;
      csr_write_data   <= CSR_W'(kind);
      sb.set_register(CSR_UNSIGNED_KIND, CSR_W'(kind));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly well-formed numbers with random content, some noise and cut strings
   task automatic send_random_string(input logic [BASE_W-1:0] base);
      logic [CH_W-1:0]   text[$];
      logic [BASE_W-1:0] eff;
      int                n;
      int                pick;
      int                d;
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) text.push_back(CH_W'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) begin
            pick = $urandom_range(8, 13);
            text.push_back(pick == 8 ? CH_SPACE : CH_W'(pick));
         end
         pick = $urandom_range(0, 2);
         if (pick == 1) text.push_back(CH_PLUS);
         if (pick == 2) text.push_back(CH_MINUS);
         eff = base;
         if (base == BASE_AUTO || base == BASE_HEX) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
               eff = (base == BASE_AUTO) ? BASE_DEC : BASE_HEX;
            end else if (pick == 1) begin
               text.push_back(CH_ZERO);
               eff = (base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            end else begin
               text.push_back(CH_ZERO);
               text.push_back(CH_LOWER_X);
               eff = BASE_HEX;
            end
         end
         if (eff == BASE_ONE || eff > BASE_MAX) begin
            eff = BASE_DEC;
         end
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 8);
         repeat (n) begin
            d = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 35)
                                             : $urandom_range(0, int'(eff) - 1);
            if (d < 10) begin
               text.push_back(CH_ZERO + CH_W'(d));
            end else if ($urandom_range(0, 1) == 1) begin
               text.push_back(CH_LOWER_A + CH_W'(d - 10));
            end else begin
               text.push_back(CH_UPPER_A + CH_W'(d - 10));
            end
         end
         // terminator, or none so the next string cuts in
         pick = $urandom_range(0, 5);
         if (pick <= 1) text.push_back(8'h00);
         if (pick == 2) text.push_back(CH_W'($urandom_range(0, 255)));
         if (pick == 3) text.push_back(CH_W'($urandom_range(32, 47)));
         if (pick == 5) text.push_back(CH_W'($urandom_range(128, 255)));
      end
      // trailing random bytes, skipped once the number has ended
      repeat ($urandom_range(0, 2)) text.push_back(CH_W'($urandom_range(0, 255)));
      foreach (text[i]) begin
         send_word(text[i], i == 0);
      end
   endtask

   // stimulus
   initial begin : stimulus
      int                target;
      int                phase_end;
      int                phase_no;
      int                pick;
      logic [BASE_W-1:0] base;
      bit                bad;
      sb               = new();
      pacing_on        = 1'b1;
      drain_hold_req   = 1'b0;
      sent_words       = 0;
      cycle_count      = 0;
      req_ch.valid     = 1'b0;
      req_ch.ch        = '0;
      req_ch.first     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_NUMBER_BASE;
      csr_write_data   = '0;
      reset            = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // decimal: whitespace, sign, high byte after sign, idle word, wrap
      configure(BASE_DEC, 1'b0);
      send_text(" \t\n-123", 1'b1, 1'b1);
      send_text("+", 1'b1, 1'b0);
      send_word(8'hff, 1'b0);
      send_text("7", 1'b0, 1'b0);
      send_text("18446744073709551617", 1'b1, 1'b1);
      // base held from the first word across a register write
      send_text("12", 1'b1, 1'b0);
      configure(BASE_HEX, 1'b1);
      send_text("ab", 1'b0, 1'b1);

      // hex prefixes, uppercase X is no prefix, prefix with no digits
      send_text("0x1F", 1'b1, 1'b1);
      send_text("0X1", 1'b1, 1'b1);
      send_text("0xg", 1'b1, 1'b0);
      send_word(8'h80, 1'b0);
      send_text("-0", 1'b1, 1'b1);

      // auto base
      configure(BASE_AUTO, 1'b0);
      send_text("017", 1'b1, 1'b1);
      send_text("0x1a", 1'b1, 1'b1);
      send_text("08", 1'b1, 1'b1);
      send_text("0", 1'b1, 1'b1);
      send_text("  42.", 1'b1, 1'b0);

      // radix extremes
      configure(BASE_MAX, 1'b1);
      send_text("zZ9.", 1'b1, 1'b0);
      send_text("-ZZZZZZZZZZZZZZ", 1'b1, 1'b1);
      configure(6'd2, 1'b0);
      send_text("1012", 1'b1, 1'b1);

      // invalid bases under both error kinds
      configure(BASE_ONE, 1'b0);
      send_text("5", 1'b1, 1'b1);
      configure(6'd37, 1'b1);
      send_text("5", 1'b1, 1'b1);
      configure(6'd63, 1'b0);
      send_text("5", 1'b1, 1'b1);

      // random phases over random settings
      target   = sent_words + RANDOM_WORDS;
      phase_no = 0;
      while (sent_words < target) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0: base = BASE_AUTO;
            1: base = 6'd2;
            2: base = BASE_OCT;
            3: base = BASE_DEC;
            4: base = BASE_HEX;
            5: base = BASE_MAX;
            6: base = ($urandom_range(0, 1) == 1) ? BASE_ONE
                                                 : BASE_W'($urandom_range(37, 63));
            default: base = BASE_W'($urandom_range(2, 36));
         endcase
         bad = (base == BASE_ONE || base > BASE_MAX);
         configure(base, 1'($urandom_range(0, 1)));
         pacing_on = ($urandom_range(0, 3) != 0);
         if (phase_no == 2 || phase_no == 6) begin
            drain_hold_req = 1'b1;
         end
         phase_end = sent_words + (bad ? BAD_STRINGS : PHASE_WORDS);
         while (sent_words < phase_end && sent_words < target) begin
            send_random_string(base);
         end
         phase_no++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("string_to_integer_parser verification clean");
      end else begin
         $display("string_to_integer_parser verification failed");
      end
      $finish;
   end

endmodule
